// File: rtl/core/ghmdl_pkg.sv
package ghmdl_pkg;

  // Eight bytes of one position, first field in the high byte
  typedef struct packed {
    logic [7:0] prior_weave_chroma;
    logic [7:0] prior_weave_luma;
    logic [7:0] weave_chroma;
    logic [7:0] weave_luma;
    logic [7:0] below_chroma;
    logic [7:0] below_luma;
    logic [7:0] above_chroma;
    logic [7:0] above_luma;
  } pos_t;

  // Vertical averages of one position
  typedef struct packed {
    logic [7:0] chroma;
    logic [7:0] luma;
  } avg_t;

  // One pixel to reconstruct: position plus neighbor averages
  typedef struct packed {
    pos_t       pos;
    avg_t       left;
    avg_t       right;
    logic       done;
  } job_t;

  typedef struct packed {
    logic [7:0] comb_margin;
    logic [7:0] motion_floor;
    logic [7:0] motion_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pixel_luma;
    logic [7:0] pixel_chroma;
    logic       row_done;
  } res_t;

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(res_t);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_COMB_MARGIN  = 2'd0;
  localparam logic [1:0] REG_MOTION_FLOOR = 2'd1;
  localparam logic [1:0] REG_MOTION_GAIN  = 2'd2;

  localparam logic [7:0] COMB_MARGIN_RST  = 8'd5;
  localparam logic [7:0] MOTION_FLOOR_RST = 8'd25;
  localparam logic [7:0] MOTION_GAIN_RST  = 8'd30;

  localparam logic [8:0] WEIGHT_MAX = 9'd256;

  function automatic logic [7:0] half_sum(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic avg_t pos_avg(input pos_t p);
    avg_t r;
    r.luma   = half_sum(p.above_luma, p.below_luma);
    r.chroma = half_sum(p.above_chroma, p.below_chroma);
    return r;
  endfunction

endpackage

// File: rtl/core/ghmdl_fifo.sv
// Small register queue, DEPTH >= 2
module ghmdl_fifo import ghmdl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/core/ghmdl_front.sv
// Front: holds one position back and turns beats into pixel jobs
module ghmdl_front import ghmdl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  pos_t in_pos,
  input  logic in_last,
  output logic job_push,
  output job_t job_data,
  input  logic job_full
);

  logic held_v_r, held_v_nxt;
  pos_t held_r, held_nxt;
  avg_t left_r, left_nxt;
  logic pend_v_r, pend_v_nxt;
  job_t pend_r, pend_nxt;

  logic accept;
  avg_t own;
  avg_t left_cur;
  job_t job_a, job_b;

  // A second job at line end waits in the pending slot until the job queue has room
  assign full   = pend_v_r || job_full;
  assign accept = push && !full;

  always_comb begin
    own      = pos_avg(in_pos);
    left_cur = held_v_r ? pos_avg(held_r) : own;
    job_a    = '{pos: held_r, left: left_r, right: own, done: 1'b0};
    job_b    = '{pos: in_pos, left: left_cur, right: own, done: 1'b1};

    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    left_nxt   = left_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    job_push   = 1'b0;
    job_data   = job_a;

    if (pend_v_r) begin
      if (!job_full) begin
        job_push   = 1'b1;
        job_data   = pend_r;
        pend_v_nxt = 1'b0;
      end
    end else if (accept) begin
      left_nxt = left_cur;
      if (held_v_r) begin
        // held pixel now has its right neighbor
        job_push = 1'b1;
        job_data = job_a;
        if (in_last) begin
          pend_v_nxt = 1'b1;
          pend_nxt   = job_b;
        end
      end else if (in_last) begin
        // one-position line
        job_push = 1'b1;
        job_data = job_b;
      end
      if (in_last) begin
        held_v_nxt = 1'b0;
      end else begin
        held_v_nxt = 1'b1;
        held_nxt   = in_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    left_r <= left_nxt;
    pend_r <= pend_nxt;
  end

endmodule

// File: rtl/core/ghmdl_back.sv
// Back: two-stage pixel datapath feeding the result queue
module ghmdl_back import ghmdl_pkg::*; #(
  parameter int OUT_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  job_t job_data,
  input  logic job_empty,
  output logic job_pop,
  output res_t out_res,
  output logic out_empty,
  input  logic out_pop
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  // Weave choice nearer the smoothed average, clamped to widened range
  function automatic logic [7:0] pick_clamped(
    input logic [7:0] up, input logic [7:0] down, input logic [7:0] cur,
    input logic [7:0] prior, input logic [7:0] avg, input logic [7:0] margin);
    logic [7:0] best, hi, lo, res;
    logic [8:0] hi_w;
    best = (abs_diff(cur, avg) > abs_diff(prior, avg)) ? prior : cur;
    hi   = (up > down) ? up : down;
    lo   = (up > down) ? down : up;
    hi_w = {1'b0, hi} + {1'b0, margin};
    hi   = hi_w[8] ? 8'hFF : hi_w[7:0];
    lo   = (lo > margin) ? (lo - margin) : 8'd0;
    if (best > hi) begin
      res = hi;
    end else if (best < lo) begin
      res = lo;
    end else begin
      res = best;
    end
    return res;
  endfunction

  avg_t        avg;
  logic [7:0]  sm_l, sm_c, ol_a, oc_a, mdiff, mexc;
  logic [15:0] mprod;
  logic [8:0]  mw_a;

  logic       s1_v_r;
  logic [7:0] s1_ol_r, s1_oc_r, s1_sm_r;
  logic [8:0] s1_mw_r;
  logic       s1_done_r;

  logic signed [9:0]  bl_d, bl_w;
  logic signed [19:0] bl_prod, bl_tot;
  res_t               res_b;

  logic [CW-1:0] out_count;
  logic [CW:0]   occupancy;

  // Take a job only when the result queue has room for all in flight
  assign occupancy = {1'b0, out_count} + {{CW{1'b0}}, s1_v_r};
  assign job_pop   = !job_empty && (occupancy < (CW+1)'(OUT_DEPTH));

  // Stage A: smoothing, choice, clamp, motion weight
  always_comb begin
    avg   = pos_avg(job_data.pos);
    sm_l  = half_sum(avg.luma, half_sum(job_data.left.luma, job_data.right.luma));
    sm_c  = half_sum(avg.chroma, half_sum(job_data.left.chroma, job_data.right.chroma));
    ol_a  = pick_clamped(job_data.pos.above_luma, job_data.pos.below_luma,
                         job_data.pos.weave_luma, job_data.pos.prior_weave_luma,
                         sm_l, cfg.comb_margin);
    oc_a  = pick_clamped(job_data.pos.above_chroma, job_data.pos.below_chroma,
                         job_data.pos.weave_chroma, job_data.pos.prior_weave_chroma,
                         sm_c, cfg.comb_margin);
    mdiff = abs_diff(job_data.pos.weave_luma, job_data.pos.prior_weave_luma);
    mexc  = (mdiff > cfg.motion_floor) ? (mdiff - cfg.motion_floor) : 8'd0;
    mprod = {8'd0, mexc} * {8'd0, cfg.motion_gain};
    mw_a  = (mprod > 16'(WEIGHT_MAX)) ? WEIGHT_MAX : mprod[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= job_pop;
    end
  end

  always_ff @(posedge clk) begin
    s1_ol_r   <= ol_a;
    s1_oc_r   <= oc_a;
    s1_sm_r   <= sm_l;
    s1_mw_r   <= mw_a;
    s1_done_r <= job_data.done;
  end

  // Stage B: luma blend, ol + (sm - ol) * w / 256
  always_comb begin
    bl_d    = $signed({2'b00, s1_sm_r}) - $signed({2'b00, s1_ol_r});
    bl_w    = $signed({1'b0, s1_mw_r});
    bl_prod = 20'(bl_d) * 20'(bl_w);
    bl_tot  = bl_prod + $signed({4'b0000, s1_ol_r, 8'h00});
    res_b   = '{pixel_luma: bl_tot[15:8], pixel_chroma: s1_oc_r, row_done: s1_done_r};
  end

  ghmdl_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_v_r),
    .wr_data (res_b),
    .full    (),
    .rd_en   (out_pop),
    .rd_data (out_res),
    .empty   (out_empty),
    .count   (out_count)
  );

endmodule

// File: rtl/core/greedy_high_motion_deinterlace_line.sv
// Channel   | Ports                                   | Beat taken when
// ----------+-----------------------------------------+------------------------------
// input     | push, full, in_* (eight bytes, end)     | push && !full
// result    | empty, pop, out_pixel_*, out_row_done   | pop && !empty
// config    | psel, penable, pwrite, paddr, pwdata    | psel && penable && pwrite
//
// One input beat per cycle while the job queue has room and no job is pending.
// A beat closing a line behind a held position stalls input until its second
// pixel job leaves the pending slot: both jobs enter the job queue through one
// write port. A job passes through the stage register into the result queue.
// Reset (rst_n low, synchronous) empties both queues, drops the held position
// and loads the register defaults. Either side may stall; the queues decouple.
module greedy_high_motion_deinterlace_line import ghmdl_pkg::*; #(
  parameter int JOB_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_above_luma,
  input  logic [7:0]  in_above_chroma,
  input  logic [7:0]  in_below_luma,
  input  logic [7:0]  in_below_chroma,
  input  logic [7:0]  in_weave_luma,
  input  logic [7:0]  in_weave_chroma,
  input  logic [7:0]  in_prior_weave_luma,
  input  logic [7:0]  in_prior_weave_chroma,
  input  logic        in_line_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_pixel_luma,
  output logic [7:0]  out_pixel_chroma,
  output logic        out_row_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r, cfg_nxt;
  logic       cfg_wr;
  logic [7:0] rd_val;
  pos_t       in_pos;
  job_t       fj_data, bj_data;
  logic       fj_push, fj_full, bj_empty, bj_pop;
  res_t       res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    rd_val  = 8'd0;
    unique case (paddr[3:2])
      REG_COMB_MARGIN: begin
        rd_val = cfg_r.comb_margin;
        if (cfg_wr) cfg_nxt.comb_margin = pwdata[7:0];
      end
      REG_MOTION_FLOOR: begin
        rd_val = cfg_r.motion_floor;
        if (cfg_wr) cfg_nxt.motion_floor = pwdata[7:0];
      end
      REG_MOTION_GAIN: begin
        rd_val = cfg_r.motion_gain;
        if (cfg_wr) cfg_nxt.motion_gain = pwdata[7:0];
      end
      default: begin
        rd_val = 8'd0;
      end
    endcase
    prdata = {24'd0, rd_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{comb_margin: COMB_MARGIN_RST, motion_floor: MOTION_FLOOR_RST,
                 motion_gain: MOTION_GAIN_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Input beat as one position
  assign in_pos = '{prior_weave_chroma: in_prior_weave_chroma,
                    prior_weave_luma:   in_prior_weave_luma,
                    weave_chroma:       in_weave_chroma,
                    weave_luma:         in_weave_luma,
                    below_chroma:       in_below_chroma,
                    below_luma:         in_below_luma,
                    above_chroma:       in_above_chroma,
                    above_luma:         in_above_luma};

  ghmdl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_pos   (in_pos),
    .in_last  (in_line_end),
    .job_push (fj_push),
    .job_data (fj_data),
    .job_full (fj_full)
  );

  ghmdl_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fj_push),
    .wr_data (fj_data),
    .full    (fj_full),
    .rd_en   (bj_pop),
    .rd_data (bj_data),
    .empty   (bj_empty),
    .count   ()
  );

  ghmdl_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_data  (bj_data),
    .job_empty (bj_empty),
    .job_pop   (bj_pop),
    .out_res   (res),
    .out_empty (empty),
    .out_pop   (pop)
  );

  assign out_pixel_luma   = res.pixel_luma;
  assign out_pixel_chroma = res.pixel_chroma;
  assign out_row_done     = res.row_done;

endmodule

// File: rtl/core/ghmdl_checker.sv
// Port-level checks for the line deinterlacer
module ghmdl_props import ghmdl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_line_end,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_pixel_luma,
  input logic [7:0]  out_pixel_chroma,
  input logic        out_row_done,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic       held_r;
  logic [7:0] ends_r;
  logic       in_beat, out_beat, wr_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;
  assign wr_beat  = psel && penable && pwrite && pready;

  // Shadow of the held position and of lines not yet closed at the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      ends_r <= '0;
    end else begin
      if (in_beat) held_r <= !in_line_end;
      ends_r <= ends_r + {7'd0, in_beat && in_line_end}
                       - {7'd0, out_beat && out_row_done};
    end
  end

  // Result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Waiting result holds while not popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pixel_luma) &&
                          $stable(out_pixel_chroma) && $stable(out_row_done)))
    else $error("waiting result changed");

  // A line end behind a held position stalls input for its second pixel job
  a_end_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_line_end && held_r) |=> full)
    else $error("line end did not stall for its second pixel");

  // row_done only for a line whose last beat was accepted
  a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_row_done) |-> (ends_r != 8'd0))
    else $error("row_done without a pending line end");

  // Register write reads back
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_beat && paddr[3:2] == REG_COMB_MARGIN) |=>
      (paddr[3:2] != REG_COMB_MARGIN || prdata[7:0] == $past(pwdata[7:0])))
    else $error("comb margin readback mismatch");

endmodule

bind greedy_high_motion_deinterlace_line ghmdl_props u_ghmdl_props (.*);
